// ===== sv/tcc_pkg.sv =====
`timescale 1ns / 1ps

package tcc_pkg;

  localparam int COLS           = 80;
  localparam int ROWS           = 25;
  localparam int FIRST_TEXT_ROW = 1;
  localparam int LAST_TEXT_ROW  = 22;
  localparam int EXTRA_ROW      = 24;

  localparam int CELLS = ROWS * COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = 7;
  localparam int RW    = 5;
  localparam int POS_W = 11;

  localparam logic HAS_EXTRA = (EXTRA_ROW < ROWS);

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0]  ATTR_RESET = 8'h0F;
  localparam logic [15:0] BLANK_CELL = 16'h0F20;

  typedef struct packed {
    logic [1:0]    operation;
    logic [7:0]    char_code;
    logic [CW-1:0] col;
    logic [RW-1:0] row;
  } req_t;

  typedef struct packed {
    logic             serial_valid;
    logic [7:0]       serial_byte;
    logic [POS_W-1:0] cursor_pos;
    logic [15:0]      cell_value;
    logic             last;
  } rsp_t;

  typedef struct packed {
    logic [CW-1:0] col;
    logic [RW-1:0] row;
    logic          scroll;
    logic          cell_wr;
  } cur_upd_t;

  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] row, logic [CW-1:0] col);
    return AW'(row) * AW'(COLS) + AW'(col);
  endfunction

endpackage

// ===== sv/text_console_cursor_engine.sv =====
`timescale 1ns / 1ps

// Channel | Signals                              | Handshake
// --------+--------------------------------------+--------------------------------------
// request | start_i, busy_o, req_i               | taken when start_i && !busy_o
// config  | cfg_valid_i, cfg_ready_o, cfg_data_i | taken when cfg_valid_i && cfg_ready_o
// result  | rsp_valid_o, rsp_o                   | one-cycle strobe, no back-pressure
//
// Plain put, set cursor and out-of-range read: result in the next cycle, busy_o stays low.
// Newline: CR then LF on consecutive cycles. In-range read: the cell is read into rd_data_q,
// then S_READ registers the result. Scroll: text rows are copied up one row and the last
// text row is blanked, one cell copy or fill per cycle on the single memory write port.
// Clear: the text rows, then the extra row, are blanked. After reset the cell memory is
// swept to blank with busy_o high. The result side cannot stall; results are strobed once.

module text_console_cursor_engine import tcc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  req_t       req_i,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_data_i,
  output logic       rsp_valid_o,
  output rsp_t       rsp_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_READ,
    S_SCROLL,
    S_FILL,
    S_LF
  } state_e;

  localparam logic [AW-1:0] COPY_START = AW'((FIRST_TEXT_ROW + 1) * COLS);
  localparam logic [AW-1:0] COPY_END   = AW'((LAST_TEXT_ROW + 1) * COLS - 1);
  localparam logic [AW-1:0] LAST_START = AW'(LAST_TEXT_ROW * COLS);
  localparam logic [AW-1:0] LAST_END   = AW'((LAST_TEXT_ROW + 1) * COLS - 1);
  localparam logic [AW-1:0] TEXT_START = AW'(FIRST_TEXT_ROW * COLS);
  localparam logic [AW-1:0] EXTRA_START = AW'(EXTRA_ROW * COLS);
  localparam logic [AW-1:0] EXTRA_END   = AW'((EXTRA_ROW + 1) * COLS - 1);
  localparam logic [AW-1:0] ROW_STEP    = AW'(COLS);

  state_e        state_q;
  logic [7:0]    attr_q;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [AW-1:0] sweep_q;
  logic          copy_pend_q;
  logic [AW-1:0] copy_addr_q;
  logic [AW-1:0] fill_q;
  logic [AW-1:0] fill_end_q;
  logic [15:0]   fill_val_q;
  logic          fill_extra_q;
  logic [7:0]    pend_ch_q;
  logic          pend_nl_q;
  logic          pend_sv_q;
  logic          rsp_valid_q;
  rsp_t          rsp_q;

  logic [15:0]   mem [CELLS];
  logic [15:0]   rd_data_q;
  logic [AW-1:0] rd_addr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [15:0]   wdata;

  cur_upd_t      upd;
  logic          accept;
  logic          rd_ok;
  logic [AW-1:0] pos_d;
  logic [AW-1:0] cur_addr;
  logic [15:0]   text_blank;

  tcc_cursor u_cursor (
    .req_i (req_i),
    .col_i (col_q),
    .row_i (row_q),
    .upd_o (upd)
  );

  assign accept     = start_i && (state_q == S_IDLE);
  assign col_d      = accept ? upd.col : col_q;
  assign row_d      = accept ? upd.row : row_q;
  assign pos_d      = cell_addr(row_d, col_d);
  assign cur_addr   = cell_addr(row_q, col_q);
  assign rd_ok      = ({1'b0, req_i.col} < (CW+1)'(COLS)) && ({1'b0, req_i.row} < (RW+1)'(ROWS));
  assign text_blank = {attr_q[7:4], 4'hF, CH_SPACE};
  assign rd_addr    = (state_q == S_SCROLL) ? sweep_q : cell_addr(req_i.row, req_i.col);

  function automatic rsp_t make_rsp(logic sv, logic [7:0] sb, logic [AW-1:0] pos,
                                    logic [15:0] cell_val, logic last);
    rsp_t r;
    r.serial_valid = sv;
    r.serial_byte  = sb;
    r.cursor_pos   = POS_W'(pos);
    r.cell_value   = cell_val;
    r.last         = last;
    return r;
  endfunction

  always_comb begin
    we    = 1'b0;
    waddr = cur_addr;
    wdata = {attr_q, req_i.char_code};
    if (copy_pend_q) begin
      we    = 1'b1;
      waddr = copy_addr_q;
      wdata = rd_data_q;
    end else if (state_q == S_INIT || state_q == S_FILL) begin
      we    = 1'b1;
      waddr = fill_q;
      wdata = fill_val_q;
    end else if (accept && req_i.operation == OP_PUT && upd.cell_wr) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      attr_q       <= ATTR_RESET;
      col_q        <= '0;
      row_q        <= RW'(FIRST_TEXT_ROW);
      sweep_q      <= '0;
      copy_pend_q  <= 1'b0;
      copy_addr_q  <= '0;
      fill_q       <= '0;
      fill_end_q   <= AW'(CELLS - 1);
      fill_val_q   <= BLANK_CELL;
      fill_extra_q <= 1'b0;
      pend_ch_q    <= '0;
      pend_nl_q    <= 1'b0;
      pend_sv_q    <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      copy_pend_q <= 1'b0;
      col_q       <= col_d;
      row_q       <= row_d;
      if (cfg_valid_i && cfg_ready_o) begin
        attr_q <= cfg_data_i;
      end
      case (state_q)
        S_INIT: begin
          fill_q <= fill_q + 1'b1;
          if (fill_q == fill_end_q) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start_i) begin
            pend_ch_q <= req_i.char_code;
            pend_nl_q <= (req_i.operation == OP_PUT) && (req_i.char_code == CH_LF);
            pend_sv_q <= (req_i.operation == OP_PUT);
            case (req_i.operation)
              OP_PUT: begin
                if (upd.scroll) begin
                  sweep_q      <= COPY_START;
                  fill_q       <= LAST_START;
                  fill_end_q   <= LAST_END;
                  fill_val_q   <= text_blank;
                  fill_extra_q <= 1'b0;
                  state_q      <= S_SCROLL;
                end else if (req_i.char_code == CH_LF) begin
                  rsp_valid_q <= 1'b1;
                  rsp_q       <= make_rsp(1'b1, CH_CR, pos_d, '0, 1'b0);
                  state_q     <= S_LF;
                end else begin
                  rsp_valid_q <= 1'b1;
                  rsp_q       <= make_rsp(1'b1, req_i.char_code, pos_d, '0, 1'b1);
                end
              end
              OP_SET: begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= make_rsp(1'b0, '0, pos_d, '0, 1'b1);
              end
              OP_CLEAR: begin
                fill_q       <= TEXT_START;
                fill_end_q   <= LAST_END;
                fill_val_q   <= text_blank;
                fill_extra_q <= HAS_EXTRA;
                state_q      <= S_FILL;
              end
              default: begin
                if (rd_ok) begin
                  state_q <= S_READ;
                end else begin
                  rsp_valid_q <= 1'b1;
                  rsp_q       <= make_rsp(1'b0, '0, pos_d, '0, 1'b1);
                end
              end
            endcase
          end
        end
        S_READ: begin
          rsp_valid_q <= 1'b1;
          rsp_q       <= make_rsp(1'b0, '0, pos_d, rd_data_q, 1'b1);
          state_q     <= S_IDLE;
        end
        S_SCROLL: begin
          copy_pend_q <= 1'b1;
          copy_addr_q <= sweep_q - ROW_STEP;
          sweep_q     <= sweep_q + 1'b1;
          if (sweep_q == COPY_END) begin
            state_q <= S_FILL;
          end
        end
        S_FILL: begin
          if (!copy_pend_q) begin
            fill_q <= fill_q + 1'b1;
            if (fill_q == fill_end_q) begin
              if (fill_extra_q) begin
                fill_q       <= EXTRA_START;
                fill_end_q   <= EXTRA_END;
                fill_val_q   <= BLANK_CELL;
                fill_extra_q <= 1'b0;
              end else begin
                rsp_valid_q <= 1'b1;
                rsp_q       <= make_rsp(pend_sv_q,
                                        pend_nl_q ? CH_CR : (pend_sv_q ? pend_ch_q : 8'h00),
                                        pos_d, '0, !pend_nl_q);
                state_q     <= pend_nl_q ? S_LF : S_IDLE;
              end
            end
          end
        end
        S_LF: begin
          rsp_valid_q <= 1'b1;
          rsp_q       <= make_rsp(1'b1, CH_LF, pos_d, '0, 1'b1);
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (rsp_q.cursor_pos < POS_W'(CELLS)))
    else $error("cursor position outside the screen");

  a_lf_after_cr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LF) |-> (rsp_valid_q && !rsp_q.last && rsp_q.serial_byte == CH_CR))
    else $error("LF not preceded by CR");

  a_copy_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    copy_pend_q |-> $past(state_q == S_SCROLL))
    else $error("copy write without scroll read");

  a_idle_no_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !copy_pend_q)
    else $error("copy write pending while idle");
`endif

endmodule

// ===== sv/tcc_cursor.sv =====
`timescale 1ns / 1ps

module tcc_cursor import tcc_pkg::*; (
  input  req_t          req_i,
  input  logic [CW-1:0] col_i,
  input  logic [RW-1:0] row_i,
  output cur_upd_t      upd_o
);

  logic [CW:0] c;
  logic [RW:0] r;
  logic        scroll;
  logic        wr;

  always_comb begin
    c      = {1'b0, col_i};
    r      = {1'b0, row_i};
    scroll = 1'b0;
    wr     = 1'b0;
    case (req_i.operation)
      OP_PUT: begin
        case (req_i.char_code)
          CH_LF: begin
            c = '0;
            r = r + 1'b1;
          end
          CH_CR: begin
            c = '0;
          end
          CH_TAB: begin
            c = (c + (CW+1)'(8)) & ~(CW+1)'(7);
          end
          CH_BS: begin
            if (c != '0) begin
              c = c - 1'b1;
            end
          end
          default: begin
            wr = 1'b1;
            c  = c + 1'b1;
          end
        endcase
        if (c >= (CW+1)'(COLS)) begin
          c = '0;
          r = r + 1'b1;
        end
        if (r > (RW+1)'(LAST_TEXT_ROW)) begin
          r      = (RW+1)'(LAST_TEXT_ROW);
          scroll = 1'b1;
        end
      end
      OP_SET: begin
        if ({1'b0, req_i.col} < (CW+1)'(COLS)) begin
          c = {1'b0, req_i.col};
        end
        if ({1'b0, req_i.row} >= (RW+1)'(FIRST_TEXT_ROW) &&
            {1'b0, req_i.row} <= (RW+1)'(LAST_TEXT_ROW)) begin
          r = {1'b0, req_i.row};
        end
      end
      OP_CLEAR: begin
        c = '0;
        r = (RW+1)'(FIRST_TEXT_ROW);
      end
      default: begin
      end
    endcase
  end

  assign upd_o.col     = c[CW-1:0];
  assign upd_o.row     = r[RW-1:0];
  assign upd_o.scroll  = scroll;
  assign upd_o.cell_wr = wr;

endmodule
